// ===== src/tcps_pkg.sv =====
// tcps_pkg: shared types, codes and sizes for the timed command playback sequencer
// no dependencies; imported by every module of the block except tcps_ram
package tcps_pkg;

  // list storage
  localparam int LIST_DEPTH = 32;
  localparam int COUNT_W    = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  // field widths
  localparam int OP_W      = 3;
  localparam int CMD_W     = 3;
  localparam int SLOT_W    = 16;
  localparam int ELAPSED_W = 17;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};
  localparam logic [SLOT_W-1:0]    SLOT_RESET  = 16'd1000;
  localparam logic [CMD_W-1:0]     CMD_STOP    = 3'd4;

  // input op codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_PLAY   = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd3;
  localparam logic [OP_W-1:0] OP_SINGLE = 3'd4;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd5;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_PLAY,
    MODE_SINGLE,
    MODE_SINGLE_RUN
  } mode_t;

  // what an accepted word produces
  typedef enum logic [1:0] {
    RES_NONE,
    RES_DIRECT,
    RES_MEM
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic apply;
    logic load_mem;
  } ctrl_cmd_t;

  typedef struct packed {
    res_t res;
  } dp_status_t;

endpackage

// ===== src/tcps_ram.sv =====
// tcps_ram: generic single write port ram with registered read
// no dependencies
module tcps_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tcps_ctrl.sv =====
// tcps_ctrl: handshake controller for the sequencer
// depends on tcps_pkg; drives tcps_dp through ctrl_cmd_t
module tcps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tcps_pkg::dp_status_t status,
  output tcps_pkg::ctrl_cmd_t  cmd
);
  import tcps_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    cmd.apply    = 1'b0;
    cmd.load_mem = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.apply = in_valid;
        if (in_valid) begin
          unique case (status.res)
            RES_DIRECT: state_next = ST_HOLD;
            RES_MEM:    state_next = ST_FETCH;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: begin
        // list entry arrives from the ram this cycle
        cmd.load_mem = 1'b1;
        state_next   = ST_HOLD;
      end
      ST_HOLD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== src/tcps_dp.sv =====
// tcps_dp: list, play state, tick counter and result register of the sequencer
// depends on tcps_pkg and tcps_ram; controlled by tcps_ctrl
module tcps_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [tcps_pkg::SLOT_W-1:0] cfg_wdata,
  input  logic [tcps_pkg::OP_W-1:0]   op,
  input  logic [tcps_pkg::CMD_W-1:0]  command_code,
  input  tcps_pkg::ctrl_cmd_t         cmd,
  output tcps_pkg::dp_status_t        status,
  output logic [tcps_pkg::CMD_W-1:0]  drive_command,
  output logic                        run_finished
);
  import tcps_pkg::*;

  logic [SLOT_W-1:0]    slot_ticks;
  logic [COUNT_W-1:0]   stored_count, stored_count_next;
  logic [COUNT_W-1:0]   play_position, play_position_next;
  mode_t                run_mode, run_mode_next;
  logic [CMD_W-1:0]     single_command, single_command_next;
  logic [ELAPSED_W-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [CMD_W-1:0]     res_cmd;
  logic                 res_fin;
  res_t                 res;
  logic                 ram_we;
  logic [CMD_W-1:0]     ram_rdata;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic                 expire;
  logic                 has_entry;

  assign elapsed_inc = (elapsed_ticks == ELAPSED_MAX) ? elapsed_ticks
                                                      : elapsed_ticks + 1'b1;
  assign expire      = elapsed_inc > {1'b0, slot_ticks};
  assign has_entry   = play_position < stored_count;

  always_comb begin
    stored_count_next   = stored_count;
    play_position_next  = play_position;
    run_mode_next       = run_mode;
    single_command_next = single_command;
    elapsed_ticks_next  = elapsed_ticks;
    res                 = RES_NONE;
    res_cmd             = CMD_STOP;
    res_fin             = 1'b0;
    ram_we              = 1'b0;
    unique case (op)
      OP_CLEAR: stored_count_next = '0;
      OP_ADD: begin
        if (stored_count < COUNT_W'(LIST_DEPTH)) begin
          ram_we            = 1'b1;
          stored_count_next = stored_count + 1'b1;
        end
      end
      OP_PLAY: begin
        elapsed_ticks_next = ELAPSED_MAX;
        play_position_next = '0;
        run_mode_next      = MODE_PLAY;
      end
      OP_STOP: begin
        run_mode_next = MODE_IDLE;
        res           = RES_DIRECT;
      end
      OP_SINGLE: begin
        elapsed_ticks_next  = ELAPSED_MAX;
        run_mode_next       = MODE_SINGLE;
        single_command_next = command_code;
      end
      OP_TICK: begin
        if (!expire) begin
          elapsed_ticks_next = elapsed_inc;
        end else begin
          elapsed_ticks_next = '0;
          unique case (run_mode)
            MODE_PLAY: begin
              if (has_entry) begin
                play_position_next = play_position + 1'b1;
                res                = RES_MEM;
              end else begin
                run_mode_next = MODE_IDLE;
                res           = RES_DIRECT;
                res_fin       = 1'b1;
              end
            end
            MODE_SINGLE: begin
              run_mode_next = MODE_SINGLE_RUN;
              res           = RES_DIRECT;
              res_cmd       = single_command;
            end
            MODE_SINGLE_RUN: begin
              run_mode_next = MODE_IDLE;
              res           = RES_DIRECT;
              res_fin       = 1'b1;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign status.res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_ticks     <= SLOT_RESET;
      stored_count   <= '0;
      play_position  <= '0;
      run_mode       <= MODE_IDLE;
      single_command <= '0;
      elapsed_ticks  <= '0;
    end else begin
      if (cfg_we) begin
        slot_ticks <= cfg_wdata;
      end
      if (cmd.apply) begin
        stored_count   <= stored_count_next;
        play_position  <= play_position_next;
        run_mode       <= run_mode_next;
        single_command <= single_command_next;
        elapsed_ticks  <= elapsed_ticks_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply && res == RES_DIRECT) begin
      drive_command <= res_cmd;
      run_finished  <= res_fin;
    end else if (cmd.load_mem) begin
      drive_command <= ram_rdata;
      run_finished  <= 1'b0;
    end
  end

  // read port follows the play position, so the entry is captured at the accepting edge
  tcps_ram #(
    .WIDTH (CMD_W),
    .DEPTH (LIST_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.apply && ram_we),
    .waddr (stored_count[ADDR_W-1:0]),
    .wdata (command_code),
    .raddr (play_position[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

endmodule

// ===== src/timed_command_playback_sequencer.sv =====
// timed_command_playback_sequencer: top level of the command recorder and player
// depends on tcps_pkg, tcps_ctrl, tcps_dp (which holds tcps_ram)
//
// usage
//   input channel (in_valid/in_ready, op, command_code) takes one word per op:
//   clear, add, play, stop, run single or tick. output channel (out_valid/out_ready,
//   drive_command, run_finished) carries at most one word per input word
//   cfg_we/cfg_wdata write slot_ticks in one cycle; write only while idle
// timing
//   a word that gives no result is taken in one cycle and in_ready stays high
//   a stop op, or a tick that ends a slot in single mode or at the end of the list,
//   shows its result the cycle after acceptance
//   a tick that plays a list entry takes one more cycle for the registered ram read
//   so its result appears two cycles after acceptance
//   the block handles one word at a time: in_ready is low from acceptance of a word
//   with a result until that result is taken, so a word with a result costs
//   2 or 3 cycles plus any receiver stall
// reset
//   rst (synchronous) empties the list, goes idle, clears the tick counter and
//   sets slot_ticks to 1000; list contents are left as they are
// stalls
//   while out_ready is low the result is held steady and no input is taken
module timed_command_playback_sequencer (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [tcps_pkg::SLOT_W-1:0] cfg_wdata,
  // input words
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcps_pkg::OP_W-1:0]   op,
  input  logic [tcps_pkg::CMD_W-1:0]  command_code,
  // result words
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcps_pkg::CMD_W-1:0]  drive_command,
  output logic                        run_finished
);
  import tcps_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // handshake sequencing
  tcps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // list, mode, tick counter and result register
  tcps_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .op            (op),
    .command_code  (command_code),
    .cmd           (cmd),
    .status        (status),
    .drive_command (drive_command),
    .run_finished  (run_finished)
  );

endmodule

// ===== src/tcps_chk.sv =====
// tcps_chk: port level checks for the sequencer, bound to the top level
// depends on tcps_pkg
module tcps_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [tcps_pkg::OP_W-1:0]   op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [tcps_pkg::CMD_W-1:0]  drive_command,
  input logic                        run_finished
);
  import tcps_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(drive_command) && $stable(run_finished))
    else $error("result changed under stall");

  // one word in flight at a time
  a_excl: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input taken while result pending");

  // a finished run always reports a stop
  a_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_finished |-> drive_command == CMD_STOP)
    else $error("run_finished without stop");

  // explicit stop answers next cycle
  a_stop: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_STOP |=>
      out_valid && drive_command == CMD_STOP && !run_finished)
    else $error("stop op not answered");

  // ops other than stop and tick give no result
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op != OP_STOP && op != OP_TICK |=> in_ready)
    else $error("unexpected result");

endmodule

bind timed_command_playback_sequencer tcps_chk u_tcps_chk (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .op            (op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .drive_command (drive_command),
  .run_finished  (run_finished)
);
